// ----- rtl/core/hts_pkg.sv -----
// Shared constants for the histogram triangular smoother.
package hts_pkg;

  // Bin and result sample width (signed Q8.8)
  localparam int unsigned DATA_W = 16;

  // Configuration register field width and reset value
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] HALF_WIDTH_RST = 5'd4;

  // Default largest half-width of the window
  localparam int unsigned MAX_WIDTH_DEF = 16;

  // APB port geometry
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_HALF_WIDTH = 1'b0;

endpackage

// ----- rtl/core/histogram_triangular_smoother.sv -----
// Histogram triangular smoother: bin store, weighted tap accumulator and divider.
//
// Bins come in on the slave stream one per transfer: tdata carries the signed
// Q8.8 value, tuser the undefined flag and tlast marks the final bin. Smoothed
// bins leave on the master stream, tdata the signed Q8.8 result and tlast set on
// the result for the final bin. The half-width W is the APB register at byte
// address 0 (0 acts as 1, above MAX_WIDTH acts as MAX_WIDTH).
// A bin's result is sent once W-1 later bins have been taken; the final bin
// flushes every pending result, oldest first. A bin that releases no result
// is taken and checked. Each result runs 2W-1 taps (one memory read and one
// multiply per tap), a pipeline drain, a division set-up step, a restoring
// division over ACC_W bits (26 at MAX_WIDTH 16), the load of the output
// register and a check step. The single bin-store read port and the shared
// divider set this sequence. A new bin is taken only once all results that
// the previous bin released are computed and loaded.
// Reset empties the histogram and sets W to 4; the bin store needs no clearing.
// When the receiver stalls, the held result waits in the output register while
// the next one is computed; the block then waits to load it.
module histogram_triangular_smoother #(
  parameter int unsigned MAX_WIDTH = hts_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Bin stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hts_pkg::DATA_W-1:0]    s_axis_tdata,   // [15:0] bin_value
  input  logic                          s_axis_tuser,   // [0] bin_undefined
  input  logic                          s_axis_tlast,   // bin_last
  // Smoothed stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [hts_pkg::DATA_W-1:0]    m_axis_tdata,   // [15:0] smoothed_value
  output logic                          m_axis_tlast,   // result_last
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hts_pkg::APB_AW-1:0]    paddr,
  input  logic [hts_pkg::APB_DW-1:0]    pwdata,
  output logic [hts_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned DW     = hts_pkg::DATA_W;
  localparam int unsigned DEPTH  = 2 * MAX_WIDTH - 1;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SEEN_W = $clog2(DEPTH + 1);
  localparam int unsigned WT_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned T_W    = SEEN_W + 1;
  localparam int unsigned CNT_W  = $clog2(MAX_WIDTH * MAX_WIDTH + 1);
  localparam int unsigned ACC_W  = DW + CNT_W + 1;
  localparam int unsigned PROD_W = DW + WT_W + 1;
  localparam int unsigned DC_W   = $clog2(ACC_W + 1);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_CHECK    = 7'b0000010,
    ST_TAPS     = 7'b0000100,
    ST_DRAIN    = 7'b0001000,
    ST_DIV_INIT = 7'b0010000,
    ST_DIV      = 7'b0100000,
    ST_OUT      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration register
  logic [hts_pkg::CFG_W-1:0] half_width_q;
  logic [WT_W-1:0]           w;

  // Bin store and histogram bookkeeping
  logic [DW:0]        mem [DEPTH];
  logic [DW:0]        rd_q;
  logic [AW-1:0]      head_q, head_d;
  logic [SEEN_W-1:0]  bins_seen_q, bins_seen_d;
  logic [WT_W-1:0]    pending_q, pending_d;
  logic               last_q, last_d;

  // Tap sequencer
  logic signed [T_W-1:0] t_q, t_d;
  logic [WT_W-1:0]       wt_q, wt_d;
  logic                  rising_q, rising_d;
  logic                  tap_centre, tap_last, tap_inrange;
  logic signed [T_W-1:0] diff, addr_full;
  logic [AW-1:0]         rd_addr;
  logic                  emit;

  // Read stage and product stage
  logic               b_vld_q, b_inrange_q, b_centre_q, b_last_q;
  logic [WT_W-1:0]    b_wt_q;
  logic               c_vld_q, c_last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     centre_undef_q;

  // Divider
  logic [ACC_W-1:0]   quo_q;
  logic [CNT_W:0]     rem_q;
  logic [DC_W-1:0]    div_cnt_q;
  logic               neg_q;
  logic [CNT_W:0]     rem_shift;
  logic               rem_ge;
  logic [DW-1:0]      q_mag, q_res;

  // Output register
  logic               m_tvalid_q;
  logic [DW-1:0]      m_tdata_q;
  logic               m_tlast_q;
  logic               out_free, out_load, in_xfer, cfg_wr;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_tvalid_q || m_axis_tready;
  assign out_load = (state_q == ST_OUT) && out_free;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == hts_pkg::REG_HALF_WIDTH);
  assign prdata = (paddr[2] == hts_pkg::REG_HALF_WIDTH) ?
                  hts_pkg::APB_DW'(half_width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= hts_pkg::HALF_WIDTH_RST;
    end else if (cfg_wr) begin
      half_width_q <= pwdata[hts_pkg::CFG_W-1:0];
    end
  end

  // Effective half-width, clamped to 1 .. MAX_WIDTH
  always_comb begin
    if (half_width_q == '0) begin
      w = WT_W'(1);
    end else if (32'(half_width_q) > MAX_WIDTH) begin
      w = WT_W'(MAX_WIDTH);
    end else begin
      w = WT_W'(half_width_q);
    end
  end

  // Tap decode: weight climbs to W at the centre, then falls back to 1
  assign tap_centre  = (wt_q == w);
  assign tap_last    = (wt_q == WT_W'(1)) && (!rising_q || tap_centre);
  assign tap_inrange = !t_q[T_W-1] && (t_q[SEEN_W-1:0] < bins_seen_q);
  assign emit        = last_q ? (pending_q != '0) : (pending_q >= w);

  // Age to store address, circular from the newest entry
  always_comb begin
    diff      = $signed(T_W'(head_q)) - t_q;
    addr_full = diff[T_W-1] ? diff + $signed(T_W'(DEPTH)) : diff;
    rd_addr   = t_q[T_W-1] ? head_q : addr_full[AW-1:0];
  end

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    bins_seen_d = bins_seen_q;
    pending_d   = pending_q;
    last_d      = last_q;
    t_d         = t_q;
    wt_d        = wt_q;
    rising_d    = rising_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
          if (bins_seen_q < SEEN_W'(DEPTH)) bins_seen_d = bins_seen_q + SEEN_W'(1);
          if (pending_q < WT_W'(MAX_WIDTH)) pending_d = pending_q + WT_W'(1);
          last_d  = s_axis_tlast;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (emit) begin
          t_d      = $signed(T_W'(pending_q) + T_W'(w) - T_W'(2));
          wt_d     = WT_W'(1);
          rising_d = 1'b1;
          state_d  = ST_TAPS;
        end else begin
          if (last_q) bins_seen_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_TAPS: begin
        t_d      = t_q - $signed(T_W'(1));
        rising_d = rising_q && !tap_centre;
        wt_d     = (rising_q && !tap_centre) ? wt_q + WT_W'(1) : wt_q - WT_W'(1);
        if (tap_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (c_vld_q && c_last_q) state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == DC_W'(1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          pending_d = pending_q - WT_W'(1);
          state_d   = ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      bins_seen_q <= '0;
      pending_q   <= '0;
      last_q      <= 1'b0;
      t_q         <= '0;
      wt_q        <= '0;
      rising_q    <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      div_cnt_q   <= '0;
      m_tvalid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      bins_seen_q <= bins_seen_d;
      pending_q   <= pending_d;
      last_q      <= last_d;
      t_q         <= t_d;
      wt_q        <= wt_d;
      rising_q    <= rising_d;
      b_vld_q     <= (state_q == ST_TAPS);
      c_vld_q     <= b_vld_q;
      if (state_q == ST_DIV_INIT) begin
        div_cnt_q <= DC_W'(ACC_W);
      end else if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q - DC_W'(1);
      end
      m_tvalid_q  <= (m_tvalid_q && !m_axis_tready) || out_load;
    end
  end

  // Bin store: write on each bin transfer, registered read for the taps
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mem[head_d] <= {s_axis_tuser, s_axis_tdata};
    end
    if (state_q == ST_TAPS) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Tap pipeline: weight product, weighted sum, divisor sum and centre flag
  always_ff @(posedge clk_i) begin
    b_inrange_q <= tap_inrange;
    b_centre_q  <= tap_centre;
    b_last_q    <= tap_last;
    b_wt_q      <= wt_q;
    c_last_q    <= b_last_q;
    if (b_inrange_q && !rd_q[DW]) begin
      prod_q <= PROD_W'($signed(rd_q[DW-1:0])) * PROD_W'($signed({1'b0, b_wt_q}));
    end else begin
      prod_q <= '0;
    end
    if (state_q == ST_CHECK) begin
      cnt_q <= '0;
    end else if (b_vld_q && b_inrange_q) begin
      cnt_q <= cnt_q + CNT_W'(b_wt_q);
    end
    if (b_vld_q && b_centre_q) begin
      centre_undef_q <= rd_q[DW];
    end
    if (state_q == ST_CHECK) begin
      acc_q <= '0;
    end else if (c_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Restoring division of the magnitude, one quotient bit per cycle
  assign rem_shift = {rem_q[CNT_W-1:0], quo_q[ACC_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, cnt_q});

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_INIT) begin
      neg_q <= acc_q[ACC_W-1];
      quo_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      quo_q <= {quo_q[ACC_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_shift - {1'b0, cnt_q} : rem_shift;
    end
  end

  // Sign restore and zero for an undefined centre; truncation toward zero falls out of the magnitude division
  assign q_mag = quo_q[DW-1:0];
  assign q_res = centre_undef_q ? '0 : (neg_q ? (~q_mag) + DW'(1) : q_mag);

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= q_res;
      m_tlast_q <= last_q && (pending_q == WT_W'(1));
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tlast  = m_tlast_q;

  // Checks
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= WT_W'(MAX_WIDTH))
    else $error("pending count above MAX_WIDTH");

  a_pending_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SEEN_W'(pending_q) <= bins_seen_q)
    else $error("more pending results than bins in the histogram");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_INIT) |-> (cnt_q != '0))
    else $error("division started with a zero divisor");

  a_tap_pipe_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |-> (state_q == ST_TAPS || state_q == ST_DRAIN))
    else $error("tap pipeline busy outside the tap phase");

  a_last_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_tvalid_q) && m_tlast_q) |-> (pending_q == '0))
    else $error("final result sent with results still pending");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the histogram triangular smoother.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_W         = hts_pkg::MAX_WIDTH_DEF;
  localparam int unsigned HIST_DEPTH    = 2 * MAX_W - 1;
  localparam int unsigned SETTLE_CYCLES = 100;     // outlasts the computation of one result
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_UNTIL  = 420;     // random histograms go on until this many bins are sent
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef struct packed {
    logic signed [hts_pkg::DATA_W-1:0] value;
    logic                              last;
  } smoothed_t;

  // DUT ports
  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [hts_pkg::DATA_W-1:0] s_axis_tdata;   // [15:0] bin_value
  logic                       s_axis_tuser;   // [0] bin_undefined
  logic                       s_axis_tlast;   // bin_last
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [hts_pkg::DATA_W-1:0] m_axis_tdata;   // [15:0] smoothed_value
  logic                       m_axis_tlast;   // result_last
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [hts_pkg::APB_AW-1:0] paddr;
  logic [hts_pkg::APB_DW-1:0] pwdata;
  logic [hts_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  // Predictor state: bin history (index 0 newest), counters and width register
  bit signed [hts_pkg::DATA_W-1:0] hist_val [HIST_DEPTH];
  bit                              hist_undef [HIST_DEPTH];
  int unsigned                     hist_count = 0;
  int unsigned                     unemitted  = 0;
  logic [hts_pkg::CFG_W-1:0]       width_reg  = hts_pkg::HALF_WIDTH_RST;
  smoothed_t                       smoothed_due [$];

  // Run control
  int unsigned error_count  = 0;
  int unsigned bins_sent    = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_request = 0;
  int unsigned sink_stall   = 0;
  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;

  histogram_triangular_smoother #(
    .MAX_WIDTH(MAX_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Width in force: 0 acts as 1, anything above the maximum is clipped
  function automatic int unsigned effective_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  // Triangular-weighted average of the bin at the given age (0 = newest)
  function automatic logic [hts_pkg::DATA_W-1:0] weighted_average(int unsigned age,
                                                                  int unsigned w);
    longint      acc;
    longint      divisor;
    longint      wt;
    longint      quot;
    int unsigned j;
    if (age >= HIST_DEPTH || hist_undef[age]) return '0;
    acc     = longint'(w) * longint'(hist_val[age]);
    divisor = longint'(w);
    for (j = 1; j < w; j++) begin
      wt = longint'(w - j);
      // newer neighbour, always part of this histogram
      if (j <= age) begin
        if (!hist_undef[age - j]) acc += wt * longint'(hist_val[age - j]);
        divisor += wt;
      end
      // older neighbour, only if it belongs to this histogram
      if (age + j < hist_count && age + j < HIST_DEPTH) begin
        if (!hist_undef[age + j]) acc += wt * longint'(hist_val[age + j]);
        divisor += wt;
      end
    end
    quot = acc / divisor;   // truncates toward zero
    return quot[hts_pkg::DATA_W-1:0];
  endfunction

  // Take one accepted bin and queue the results it releases
  function automatic void predict_bin(logic signed [hts_pkg::DATA_W-1:0] value,
                                      logic undef, logic last);
    int unsigned w;
    int          i;
    smoothed_t   res;
    w = effective_width();
    for (i = HIST_DEPTH - 1; i > 0; i--) begin
      hist_val[i]   = hist_val[i-1];
      hist_undef[i] = hist_undef[i-1];
    end
    hist_val[0]   = value;
    hist_undef[0] = undef;
    if (hist_count < HIST_DEPTH) hist_count++;
    if (unemitted < MAX_W) unemitted++;
    if (last) begin
      // final bin flushes everything, window cut at the right edge
      while (unemitted > 0) begin
        res.value = weighted_average(unemitted - 1, w);
        res.last  = (unemitted == 1);
        smoothed_due.push_back(res);
        unemitted--;
      end
      hist_count = 0;
    end else begin
      while (unemitted >= w) begin
        res.value = weighted_average(unemitted - 1, w);
        res.last  = 1'b0;
        smoothed_due.push_back(res);
        unemitted--;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [hts_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return 16'($urandom_range(0, 511)) - 16'd256;
      default: return hts_pkg::DATA_W'($urandom());
    endcase
  endfunction

  function automatic logic [hts_pkg::CFG_W-1:0] pick_width();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return hts_pkg::CFG_W'(1);
      2:       return hts_pkg::CFG_W'(MAX_W);
      3:       return '1;
      4:       return hts_pkg::CFG_W'(MAX_W + 1);
      default: return hts_pkg::CFG_W'($urandom_range(2, MAX_W - 1));
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offer one bin, wait for the transfer, then maybe idle
  task automatic send_bin(input logic signed [hts_pkg::DATA_W-1:0] value,
                          input logic undef, input logic last);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= undef;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_bin(value, undef, last);
    bins_sent++;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering, wait until every queued result has been taken, then settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (smoothed_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write of half_width followed by a read-back
  task automatic cfg_half_width(input logic [hts_pkg::CFG_W-1:0] w);
    logic [hts_pkg::APB_DW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {hts_pkg::REG_HALF_WIDTH, 2'b00};
    pwdata  <= hts_pkg::APB_DW'(w);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    width_reg = w;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (readback !== hts_pkg::APB_DW'(w))
      report_mismatch("half_width read-back", int'(readback), int'(w));
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: random stalls plus the long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      sink_stall   = hold_request;
      hold_request = 0;
    end
    if (sink_stall == 0 && sink_idle_on) sink_stall = pick_gap();
    if (sink_stall != 0) begin
      m_axis_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_smoothed
    smoothed_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (smoothed_due.size() == 0) begin
        report_mismatch("unexpected result", int'($signed(m_axis_tdata)), 0);
      end else begin
        want = smoothed_due.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch($sformatf("smoothed_value of result %0d", results_seen),
                          int'($signed(m_axis_tdata)), int'(want.value));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("result_last of result %0d", results_seen),
                          int'(m_axis_tlast), int'(want.last));
      end
    end
  end

  // Run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset width, value extremes, undefined centre, one-bin histograms
  task automatic test_default_width();
    send_bin(16'sh7FFF, 1'b0, 1'b0);
    send_bin(16'sh7FFF, 1'b0, 1'b0);
    send_bin(16'sh8000, 1'b0, 1'b0);
    send_bin(16'sh8000, 1'b0, 1'b0);
    send_bin(16'sh0000, 1'b1, 1'b0);
    send_bin(-16'sd1,   1'b0, 1'b0);
    send_bin(16'sd1,    1'b0, 1'b0);
    send_bin(16'sh8000, 1'b0, 1'b1);
    send_bin(16'sh8000, 1'b0, 1'b1);
    send_bin(16'sh7FFF, 1'b1, 1'b1);
    // histogram with nothing defined
    send_bin(16'sd123,  1'b1, 1'b0);
    send_bin(-16'sd5,   1'b1, 1'b1);
    drain_results();
  endtask

  // Width zero acts as one, above the maximum acts as the maximum
  task automatic test_width_limits();
    cfg_half_width('0);
    send_bin(16'sh7FFF, 1'b0, 1'b0);
    send_bin(16'sh8000, 1'b1, 1'b0);
    send_bin(16'sd300,  1'b0, 1'b1);
    drain_results();
    cfg_half_width('1);
    send_bin(16'sh8000, 1'b0, 1'b0);
    send_bin(16'sh7FFF, 1'b0, 1'b0);
    send_bin(-16'sd77,  1'b0, 1'b1);
    drain_results();
  endtask

  // Shrinking the width mid-histogram releases every bin now due
  task automatic test_width_shrink();
    int k;
    cfg_half_width(hts_pkg::CFG_W'(MAX_W));
    for (k = 0; k < 6; k++) send_bin(pick_value(), k == 2, 1'b0);
    drain_results();
    cfg_half_width(hts_pkg::CFG_W'(2));
    send_bin(pick_value(), 1'b0, 1'b0);
    send_bin(pick_value(), 1'b0, 1'b1);
    drain_results();
  endtask

  // Random histograms over many widths, some with a width change inside
  task automatic test_random_histograms();
    int unsigned len;
    int unsigned cut;
    int unsigned k;
    while (bins_sent < RANDOM_UNTIL) begin
      if ($urandom_range(0, 2) != 0) begin
        drain_results();
        cfg_half_width(pick_width());
      end
      src_idle_on  = ($urandom_range(0, 4) != 0);
      sink_idle_on = ($urandom_range(0, 4) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 20);
      cut = (len > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : 0;
      for (k = 0; k < len; k++) begin
        if (cut != 0 && k == cut) begin
          drain_results();
          cfg_half_width(hts_pkg::CFG_W'($urandom_range(0, 31)));
        end
        send_bin(pick_value(), $urandom_range(0, 99) < 15, k == len - 1);
      end
    end
    drain_results();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Receiver holds off while bins keep coming, so the input stalls
  task automatic test_output_backpressure();
    int k;
    cfg_half_width(hts_pkg::CFG_W'(3));
    src_idle_on  = 1'b0;
    hold_request = HOLD_CYCLES;
    for (k = 0; k < 40; k++) send_bin(pick_value(), $urandom_range(0, 9) == 0, k == 39);
    drain_results();
    src_idle_on = 1'b1;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_width();
    test_width_limits();
    test_width_shrink();
    test_random_histograms();
    test_output_backpressure();

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/hts_pkg.sv
rtl/core/histogram_triangular_smoother.sv
tb/sv/testbench.sv
